// File: hw/rtl/raycast_wall_slice_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the raycast wall slice core
// Checks are compiled in simulation and drop out under synthesis.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_SLICE_CORE_MACROS_SVH
`define RAYCAST_WALL_SLICE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk_i, off during reset
`define RWSC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwsc check failed");
// next-cycle implication
`define RWSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwsc check failed");
`else
`define RWSC_ASSERT(lbl, ante, cons)
`define RWSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/rwsc_pkg.sv
// ----------------------------------------------------------------------------
// rwsc_pkg
// Constants and payload types shared by the wall slice pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rwsc_pkg;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned HALF_SCREEN   = SCREEN_HEIGHT / 2;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned CELL_W = 8;
  localparam int unsigned DIR_W  = 19;
  localparam int unsigned DIST_W = 24;
  localparam int unsigned HGT_W  = 16;
  localparam int unsigned ROW_W  = 9;
  localparam int unsigned TEX_W  = 10;
  localparam int unsigned TW_W   = 11;

  // numerator is cell*2^F - pos + 2^F, magnitude up to 2^24
  localparam int unsigned NUM_W   = POS_W + 2;
  localparam int unsigned MAG_W   = NUM_W - 1;
  localparam int unsigned DIVA_NW = MAG_W + FRAC_BITS;
  localparam int unsigned DIVA_DW = DIR_W;
  localparam int unsigned HNUM_W  = 25;
  localparam int unsigned FRAC2_W = 2 * FRAC_BITS;

  localparam logic [TW_W-1:0]   TEX_MAX    = TW_W'(1024);
  localparam logic [HGT_W-1:0]  HEIGHT_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;
  localparam logic [HNUM_W-1:0] HEIGHT_NUM = HNUM_W'(SCREEN_HEIGHT << FRAC_BITS);

  // rides along the distance divider
  typedef struct packed {
    logic                    degen;
    logic [FRAC_BITS-1:0]    pos_lo;
    logic signed [DIR_W-1:0] dir;
    logic                    mirror;
  } rwsc_ray_t;

  // distance and flag, carried through the texel stages
  typedef struct packed {
    logic [DIST_W-1:0] wall_dist;
    logic              degen;
  } rwsc_slice_t;

  // rides along the height divider
  typedef struct packed {
    rwsc_slice_t      slice;
    logic [TEX_W-1:0] texel;
  } rwsc_col_t;

endpackage

`default_nettype wire

// File: hw/rtl/rwsc_div_pipe.sv
// ----------------------------------------------------------------------------
// rwsc_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rwsc_div_pipe #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 19,
  parameter int unsigned PAY_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [PAY_W-1:0] pay_i,
  output logic                  valid_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [PAY_W-1:0]      pay_o
);

  logic             valid_q [NUM_W];
  logic [DEN_W-1:0] rem_q   [NUM_W];
  logic [NUM_W-1:0] dq_q    [NUM_W];
  logic [DEN_W-1:0] den_q   [NUM_W];
  logic [PAY_W-1:0] pay_q   [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             src_valid;
    logic [DEN_W-1:0] src_rem;
    logic [NUM_W-1:0] src_dq;
    logic [DEN_W-1:0] src_den;
    logic [PAY_W-1:0] src_pay;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_rem   = '0;
      assign src_dq    = num_i;
      assign src_den   = den_i;
      assign src_pay   = pay_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_rem   = rem_q[k-1];
      assign src_dq    = dq_q[k-1];
      assign src_den   = den_q[k-1];
      assign src_pay   = pay_q[k-1];
    end

    // shift in the next dividend bit, subtract if it fits
    assign trial = {src_rem, src_dq[NUM_W-1]};
    assign diff  = trial - {1'b0, src_den};
    assign ge    = (trial >= {1'b0, src_den});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dq_q[k]  <= {src_dq[NUM_W-2:0], ge};
        den_q[k] <= src_den;
        pay_q[k] <= src_pay;
      end
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign quo_o   = dq_q[NUM_W-1];
  assign pay_o   = pay_q[NUM_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/rwsc_texel.sv
// ----------------------------------------------------------------------------
// rwsc_texel
// Four-stage texture column unit: hit point, fraction scale, mirroring.
// ----------------------------------------------------------------------------
`default_nettype none

module rwsc_texel
  import rwsc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire rwsc_slice_t             slice_i,
  input  wire logic [FRAC_BITS-1:0]    pos_lo_i,
  input  wire logic signed [DIR_W-1:0] dir_i,
  input  wire logic                    mirror_i,
  input  wire logic [TW_W-1:0]         width_i,
  output logic                         valid_o,
  output rwsc_slice_t                  slice_o,
  output logic [TEX_W-1:0]             texel_o
);

  localparam int unsigned PROD_W = DIST_W + 1 + DIR_W;
  localparam int unsigned SCL_W  = FRAC2_W + TW_W;

  logic [3:0]  valid_q;
  rwsc_slice_t slice_q [4];
  logic        mirror_q [3];
  logic [FRAC_BITS-1:0] pos_q;

  logic signed [PROD_W-1:0] prod;
  logic [FRAC2_W-1:0] prod_q;
  logic [FRAC2_W-1:0] frac_q;
  logic [SCL_W-1:0]   scaled;
  logic [TEX_W-1:0]   tex_q;
  logic [TW_W-1:0]    mir;
  logic [TEX_W-1:0]   texel_q;

  // distance times direction, low bits only matter
  assign prod   = $signed({1'b0, slice_i.wall_dist}) * dir_i;
  // fraction times width, integer part is the column
  assign scaled = SCL_W'(frac_q) * SCL_W'(width_i);
  assign mir    = width_i - TW_W'(tex_q) - TW_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // product stage
      prod_q      <= prod[FRAC2_W-1:0];
      pos_q       <= pos_lo_i;
      slice_q[0]  <= slice_i;
      mirror_q[0] <= mirror_i;
      // hit point fraction
      frac_q      <= {pos_q, {FRAC_BITS{1'b0}}} + prod_q;
      slice_q[1]  <= slice_q[0];
      mirror_q[1] <= mirror_q[0];
      // scale by width
      tex_q       <= scaled[FRAC2_W +: TEX_W];
      slice_q[2]  <= slice_q[1];
      mirror_q[2] <= mirror_q[1];
      // mirror, zero on degenerate or zero width
      if (slice_q[2].degen || (width_i == '0)) begin
        texel_q <= '0;
      end else if (mirror_q[2]) begin
        texel_q <= mir[TEX_W-1:0];
      end else begin
        texel_q <= tex_q;
      end
      slice_q[3] <= slice_q[2];
    end
  end

  assign valid_o = valid_q[3];
  assign slice_o = slice_q[3];
  assign texel_o = texel_q;

endmodule

`default_nettype wire

// File: hw/rtl/raycast_wall_slice_core.sv
// ----------------------------------------------------------------------------
// raycast_wall_slice_core
// Wall slice projection for one ray that has hit a wall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one ray word: player
//   position, hit cell, step signs, ray direction and hit side. Output
//   channel (out_valid_o / out_ready_i) returns one column word: wall
//   distance, slice height, first and last rows, texel column, degenerate.
//   texture_width_we_i writes the texture width; write it only while idle.
//   Stages: 1 prep, 41 distance divider steps (one quotient bit per
//   stage), 1 saturation, 4 texel, 25 height divider steps and the output
//   register. Throughput is one ray per clock unless the output stalls.
//   Reset empties the pipeline and sets the texture width to 64.
//   When the receiver holds out_ready_i low with a word waiting, the whole
//   pipeline freezes and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module raycast_wall_slice_core
  import rwsc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    texture_width_we_i,
  input  wire logic [TW_W-1:0]         texture_width_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [POS_W-1:0]        player_x_i,
  input  wire logic [POS_W-1:0]        player_y_i,
  input  wire logic [CELL_W-1:0]       cell_x_i,
  input  wire logic [CELL_W-1:0]       cell_y_i,
  input  wire logic                    step_x_neg_i,
  input  wire logic                    step_y_neg_i,
  input  wire logic signed [DIR_W-1:0] dir_x_i,
  input  wire logic signed [DIR_W-1:0] dir_y_i,
  input  wire logic                    hit_side_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [DIST_W-1:0]            wall_distance_o,
  output logic [HGT_W-1:0]             slice_height_o,
  output logic [ROW_W-1:0]             first_row_o,
  output logic [ROW_W-1:0]             last_row_o,
  output logic [TEX_W-1:0]             texel_column_o,
  output logic                         degenerate_o
);

`include "raycast_wall_slice_core_macros.svh"

  localparam int unsigned RAY_W = $bits(rwsc_ray_t);
  localparam int unsigned COL_W = $bits(rwsc_col_t);

  logic en;
  logic [TW_W-1:0] texture_width_q;
  logic [TW_W-1:0] tex_w;

  // global advance: move when the output slot is free or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // texture width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      texture_width_q <= TW_W'(64);
    end else if (texture_width_we_i) begin
      texture_width_q <= texture_width_i;
    end
  end
  assign tex_w = (texture_width_q > TEX_MAX) ? TEX_MAX : texture_width_q;

  // prep: numerator, magnitudes and sign cases
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        num_mag;
  logic [DIR_W-1:0]        den_mag;
  logic signed [DIR_W-1:0] den;
  logic                    side_neg;
  rwsc_ray_t               ray_d;
  logic                    prep_valid_q;
  logic [DIVA_NW-1:0]      prep_num_q;
  logic [DIVA_DW-1:0]      prep_den_q;
  rwsc_ray_t               prep_ray_q;

  always_comb begin
    if (!hit_side_i) begin
      num = $signed({2'b00, cell_x_i, {FRAC_BITS{1'b0}}})
          - $signed({2'b00, player_x_i});
      side_neg = step_x_neg_i;
      den = dir_x_i;
    end else begin
      num = $signed({2'b00, cell_y_i, {FRAC_BITS{1'b0}}})
          - $signed({2'b00, player_y_i});
      side_neg = step_y_neg_i;
      den = dir_y_i;
    end
    if (side_neg) begin
      num = num + $signed(NUM_W'(1 << FRAC_BITS));
    end
    num_mag = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
    den_mag = den[DIR_W-1] ? DIR_W'(-den) : den;
    ray_d.degen  = (den == '0) || (num == '0) || (num[NUM_W-1] != den[DIR_W-1]);
    ray_d.pos_lo = hit_side_i ? player_x_i[FRAC_BITS-1:0] : player_y_i[FRAC_BITS-1:0];
    ray_d.dir    = hit_side_i ? dir_x_i : dir_y_i;
    ray_d.mirror = (!hit_side_i && !dir_x_i[DIR_W-1] && (dir_x_i != '0))
                || (hit_side_i && dir_y_i[DIR_W-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_num_q <= {num_mag, {FRAC_BITS{1'b0}}};
      prep_den_q <= den_mag;
      prep_ray_q <= ray_d;
    end
  end

  // distance divider
  logic               diva_valid;
  logic [DIVA_NW-1:0] diva_quo;
  logic [RAY_W-1:0]   diva_pay;
  rwsc_ray_t          diva_ray;

  rwsc_div_pipe #(
    .NUM_W (DIVA_NW),
    .DEN_W (DIVA_DW),
    .PAY_W (RAY_W)
  ) u_div_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid_q),
    .num_i   (prep_num_q),
    .den_i   (prep_den_q),
    .pay_i   (prep_ray_q),
    .valid_o (diva_valid),
    .quo_o   (diva_quo),
    .pay_o   (diva_pay)
  );
  assign diva_ray = rwsc_ray_t'(diva_pay);

  // saturate distance, fold in zero quotient
  logic        sat_degen;
  logic        sat_valid_q;
  rwsc_slice_t sat_slice_q;
  rwsc_ray_t   sat_ray_q;

  assign sat_degen = diva_ray.degen || (diva_quo == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_valid_q <= 1'b0;
    end else if (en) begin
      sat_valid_q <= diva_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_slice_q.degen <= sat_degen;
      if (sat_degen) begin
        sat_slice_q.wall_dist <= '0;
      end else if (|diva_quo[DIVA_NW-1:DIST_W]) begin
        sat_slice_q.wall_dist <= DIST_MAX;
      end else begin
        sat_slice_q.wall_dist <= diva_quo[DIST_W-1:0];
      end
      sat_ray_q <= diva_ray;
    end
  end

  // texture column
  logic             tx_valid;
  rwsc_slice_t      tx_slice;
  logic [TEX_W-1:0] tx_texel;
  rwsc_col_t        tx_col;

  rwsc_texel u_texel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sat_valid_q),
    .slice_i  (sat_slice_q),
    .pos_lo_i (sat_ray_q.pos_lo),
    .dir_i    (sat_ray_q.dir),
    .mirror_i (sat_ray_q.mirror),
    .width_i  (tex_w),
    .valid_o  (tx_valid),
    .slice_o  (tx_slice),
    .texel_o  (tx_texel)
  );
  assign tx_col.slice = tx_slice;
  assign tx_col.texel = tx_texel;

  // height divider
  logic              divh_valid;
  logic [HNUM_W-1:0] divh_quo;
  logic [COL_W-1:0]  divh_pay;
  rwsc_col_t         divh_col;

  rwsc_div_pipe #(
    .NUM_W (HNUM_W),
    .DEN_W (DIST_W),
    .PAY_W (COL_W)
  ) u_div_height (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tx_valid),
    .num_i   (HEIGHT_NUM),
    .den_i   (tx_slice.wall_dist),
    .pay_i   (tx_col),
    .valid_o (divh_valid),
    .quo_o   (divh_quo),
    .pay_o   (divh_pay)
  );
  assign divh_col = rwsc_col_t'(divh_pay);

  // height saturation and row clamps
  logic [HGT_W-1:0]   height;
  logic [HGT_W-2:0]   half_h;
  logic [ROW_W-1:0]   first_row;
  logic [ROW_W-1:0]   last_row;

  always_comb begin
    if (divh_col.slice.degen || (|divh_quo[HNUM_W-1:HGT_W])) begin
      height = HEIGHT_MAX;
    end else begin
      height = divh_quo[HGT_W-1:0];
    end
    half_h = height[HGT_W-1:1];
    if (half_h >= (HGT_W-1)'(HALF_SCREEN)) begin
      first_row = '0;
    end else begin
      first_row = ROW_W'(HALF_SCREEN) - half_h[ROW_W-1:0];
    end
    if (half_h >= (HGT_W-1)'(SCREEN_HEIGHT - 1 - HALF_SCREEN)) begin
      last_row = ROW_W'(SCREEN_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(HALF_SCREEN) + half_h[ROW_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= divh_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wall_distance_o <= divh_col.slice.wall_dist;
      slice_height_o  <= height;
      first_row_o     <= first_row;
      last_row_o      <= last_row;
      texel_column_o  <= divh_col.texel;
      degenerate_o    <= divh_col.slice.degen;
    end
  end

  // checks
  `RWSC_ASSERT(a_degen_fields, out_valid_o && degenerate_o,
    (wall_distance_o == '0) && (texel_column_o == '0) && (slice_height_o == HEIGHT_MAX))
  `RWSC_ASSERT(a_dist_nonzero, out_valid_o && !degenerate_o, wall_distance_o != '0)
  `RWSC_ASSERT(a_row_order, out_valid_o, first_row_o <= last_row_o)
  `RWSC_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(slice_height_o) && $stable(texel_column_o))

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// raycast_wall_slice_core testbench
// Drives ray words through the core under random idling on both channels and
// checks every column word against a bit-accurate predictor of the slice math.
// The texture width is rewritten between phases, including zero and oversize.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rwsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 90;

  typedef struct {
    logic [POS_W-1:0]        player_x;
    logic [POS_W-1:0]        player_y;
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic                    step_x_neg;
    logic                    step_y_neg;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic                    hit_side;
  } ray_t;

  typedef struct {
    logic [DIST_W-1:0] wall_distance;
    logic [HGT_W-1:0]  slice_height;
    logic [ROW_W-1:0]  first_row;
    logic [ROW_W-1:0]  last_row;
    logic [TEX_W-1:0]  texel_column;
    logic              degenerate;
  } column_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic tw_we = 1'b0;
  logic [TW_W-1:0] tw_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  ray_t ray_drv = '{default: '0};
  column_t col_dut;

  ray_t    pending_rays[$];
  column_t expected_cols[$];
  logic [TW_W-1:0] tex_width = TW_W'(64);
  bit      quiet = 1'b0;
  bit      failed = 1'b0;
  int unsigned cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  raycast_wall_slice_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .texture_width_we_i(tw_we),
    .texture_width_i   (tw_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .player_x_i        (ray_drv.player_x),
    .player_y_i        (ray_drv.player_y),
    .cell_x_i          (ray_drv.cell_x),
    .cell_y_i          (ray_drv.cell_y),
    .step_x_neg_i      (ray_drv.step_x_neg),
    .step_y_neg_i      (ray_drv.step_y_neg),
    .dir_x_i           (ray_drv.dir_x),
    .dir_y_i           (ray_drv.dir_y),
    .hit_side_i        (ray_drv.hit_side),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .wall_distance_o   (col_dut.wall_distance),
    .slice_height_o    (col_dut.slice_height),
    .first_row_o       (col_dut.first_row),
    .last_row_o        (col_dut.last_row),
    .texel_column_o    (col_dut.texel_column),
    .degenerate_o      (col_dut.degenerate)
  );

  // perpendicular distance, projected height, rows and texel for one ray
  function automatic column_t project_slice(ray_t r, logic [TW_W-1:0] width);
    longint one, num, den, q, wall_dist, height, half_h, first, last, w, dir, hit;
    longint unsigned frac, texel;
    bit degen;
    column_t c;
    one = longint'(1) << FRAC_BITS;
    q = 0;
    wall_dist = 0;
    texel = 0;
    degen = 1'b0;
    if (!r.hit_side) begin
      num = longint'(r.cell_x) * one - longint'(r.player_x) + (r.step_x_neg ? one : 0);
      den = longint'(r.dir_x);
    end else begin
      num = longint'(r.cell_y) * one - longint'(r.player_y) + (r.step_y_neg ? one : 0);
      den = longint'(r.dir_y);
    end
    if (den == 0) begin
      degen = 1'b1;
    end else begin
      q = (num * one) / den;
      if (q <= 0) degen = 1'b1;
    end
    if (degen) begin
      height = HEIGHT_MAX;
    end else begin
      wall_dist = (q > longint'(DIST_MAX)) ? longint'(DIST_MAX) : q;
      height = (longint'(SCREEN_HEIGHT) << FRAC_BITS) / wall_dist;
      if (height > longint'(HEIGHT_MAX)) height = HEIGHT_MAX;
    end
    half_h = height / 2;
    first = (half_h >= HALF_SCREEN) ? 0 : HALF_SCREEN - half_h;
    last = HALF_SCREEN + half_h;
    if (last > SCREEN_HEIGHT - 1) last = SCREEN_HEIGHT - 1;
    if (!degen) begin
      w = (width > TEX_MAX) ? longint'(TEX_MAX) : longint'(width);
      // hit point on the other axis in Q.2F; fraction wraps like a floor
      dir = r.hit_side ? longint'(r.dir_x) : longint'(r.dir_y);
      hit = ((r.hit_side ? longint'(r.player_x) : longint'(r.player_y)) << FRAC_BITS)
            + wall_dist * dir;
      frac = longint'(hit) & 64'hFFFF_FFFF;
      if (w != 0) begin
        texel = (frac * longint'(w)) >> (2 * FRAC_BITS);
        if ((!r.hit_side && r.dir_x > 0) || (r.hit_side && r.dir_y < 0))
          texel = w - texel - 1;
      end
    end
    c.wall_distance = wall_dist[DIST_W-1:0];
    c.slice_height  = height[HGT_W-1:0];
    c.first_row     = first[ROW_W-1:0];
    c.last_row      = last[ROW_W-1:0];
    c.texel_column  = texel[TEX_W-1:0];
    c.degenerate    = degen;
    return c;
  endfunction

  // well-formed rays hit a cell at most three cells from the player along the step sign
  function automatic ray_t make_ray(bit well_formed);
    ray_t r;
    int   k;
    int   mag;
    r.player_x   = POS_W'($urandom);
    r.player_y   = POS_W'($urandom);
    r.cell_x     = CELL_W'($urandom);
    r.cell_y     = CELL_W'($urandom);
    r.step_x_neg = 1'($urandom);
    r.step_y_neg = 1'($urandom);
    r.dir_x      = DIR_W'($urandom);
    r.dir_y      = DIR_W'($urandom);
    r.hit_side   = 1'($urandom);
    if (well_formed) begin
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0: mag = $urandom_range(1, 255);
        1: mag = $urandom_range(256, 65535);
        default: mag = $urandom_range(65536, 262143);
      endcase
      if (!r.hit_side) begin
        r.cell_x = r.step_x_neg ? r.player_x[23:16] - CELL_W'(k)
                                : r.player_x[23:16] + CELL_W'(k);
        r.dir_x  = DIR_W'(r.step_x_neg ? -mag : mag);
      end else begin
        r.cell_y = r.step_y_neg ? r.player_y[23:16] - CELL_W'(k)
                                : r.player_y[23:16] + CELL_W'(k);
        r.dir_y  = DIR_W'(r.step_y_neg ? -mag : mag);
      end
    end
    return r;
  endfunction

  // cycle count and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("raycast_wall_slice_core test failed");
      $finish;
    end
  end

  // input driver: predicts each word as it is accepted
  always @(posedge clk_i) begin
    if (in_valid && in_ready)
      expected_cols.push_back(project_slice(ray_drv, tex_width));
    if (!in_valid || in_ready) begin
      if (rst_ni && pending_rays.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
        ray_drv  <= pending_rays.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor: random back-pressure, field-by-field compare
  always @(posedge clk_i) begin
    column_t exp_col;
    if (out_valid && out_ready) begin
      if (expected_cols.size() == 0) begin
        $error("column word with no expectation");
        failed <= 1'b1;
      end else begin
        exp_col = expected_cols.pop_front();
        if (col_dut.wall_distance !== exp_col.wall_distance) begin
          $error("wall_distance exp %0h got %0h", exp_col.wall_distance, col_dut.wall_distance);
          failed <= 1'b1;
        end
        if (col_dut.slice_height !== exp_col.slice_height) begin
          $error("slice_height exp %0d got %0d", exp_col.slice_height, col_dut.slice_height);
          failed <= 1'b1;
        end
        if (col_dut.first_row !== exp_col.first_row) begin
          $error("first_row exp %0d got %0d", exp_col.first_row, col_dut.first_row);
          failed <= 1'b1;
        end
        if (col_dut.last_row !== exp_col.last_row) begin
          $error("last_row exp %0d got %0d", exp_col.last_row, col_dut.last_row);
          failed <= 1'b1;
        end
        if (col_dut.texel_column !== exp_col.texel_column) begin
          $error("texel_column exp %0d got %0d", exp_col.texel_column, col_dut.texel_column);
          failed <= 1'b1;
        end
        if (col_dut.degenerate !== exp_col.degenerate) begin
          $error("degenerate exp %0b got %0b", exp_col.degenerate, col_dut.degenerate);
          failed <= 1'b1;
        end
      end
    end
    out_ready <= rst_ni && (quiet || $urandom_range(0, 99) >= 12);
  end

  task automatic drain();
    while (pending_rays.size() > 0 || in_valid || expected_cols.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_width(logic [TW_W-1:0] value);
    @(posedge clk_i);
    tw_we     <= 1'b1;
    tw_data   <= value;
    tex_width <= value;
    @(posedge clk_i);
    tw_we <= 1'b0;
  endtask

  task automatic add_rays(int count);
    repeat (count) pending_rays.push_back(make_ray($urandom_range(0, 99) < 75));
  endtask

  // stimulus
  initial begin
    ray_t r;
    logic [TW_W-1:0] widths[7];
    widths = '{TW_W'(1), TW_W'(1024), TW_W'(0), TW_W'(2047), TW_W'(37), TW_W'(640), TW_W'(64)};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset width
    r = '{default: '0};
    pending_rays.push_back(r);                      // zero direction
    r.hit_side = 1'b1;
    pending_rays.push_back(r);                      // zero direction, y face
    r = '{player_x: '1, player_y: '1, cell_x: '1, cell_y: '1, step_x_neg: 1'b1,
          step_y_neg: 1'b1, dir_x: 19'sh3FFFF, dir_y: 19'sh3FFFF, hit_side: 1'b0};
    pending_rays.push_back(r);                      // all ones, positive dirs
    r.hit_side = 1'b1;
    pending_rays.push_back(r);
    r = '{player_x: 24'h0, player_y: 24'h0, cell_x: 8'hFF, cell_y: 8'hFF, step_x_neg: 1'b0,
          step_y_neg: 1'b0, dir_x: 19'sd1, dir_y: 19'sd1, hit_side: 1'b0};
    pending_rays.push_back(r);                      // far wall saturates
    r.hit_side = 1'b1;
    pending_rays.push_back(r);
    r = '{player_x: 24'h0200FF, player_y: 24'h07FFFF, cell_x: 8'h02, cell_y: 8'h07,
          step_x_neg: 1'b0, step_y_neg: 1'b0, dir_x: -19'sd262144, dir_y: 19'sh3FFFF,
          hit_side: 1'b0};
    pending_rays.push_back(r);                      // negative numerator and direction, positive distance
    r = '{player_x: 24'h02FFFF, player_y: 24'h058000, cell_x: 8'h03, cell_y: 8'h05,
          step_x_neg: 1'b0, step_y_neg: 1'b1, dir_x: 19'sh3FFFF, dir_y: -19'sd70000,
          hit_side: 1'b0};
    pending_rays.push_back(r);                      // quotient rounds to zero, degenerate x face
    r.hit_side = 1'b1;
    pending_rays.push_back(r);                      // y face moving minus, degenerate sign mismatch
    r = '{player_x: 24'h108000, player_y: 24'h204000, cell_x: 8'h0F, cell_y: 8'h21,
          step_x_neg: 1'b1, step_y_neg: 1'b0, dir_x: -19'sd40000, dir_y: 19'sd30000,
          hit_side: 1'b0};
    pending_rays.push_back(r);                      // x face moving minus, unmirrored
    r.hit_side = 1'b1;
    pending_rays.push_back(r);                      // y face moving plus, unmirrored
    r.dir_x = -19'sd262144;
    r.dir_y = -19'sd262144;
    pending_rays.push_back(r);
    repeat (10) pending_rays.push_back(make_ray(1'b1));
    drain();

    // random phases across texture widths, one stretch without idling
    foreach (widths[i]) begin
      write_width(widths[i]);
      quiet = (i == 4);
      add_rays(100);
      drain();
    end
    quiet = 1'b0;

    if (!failed && expected_cols.size() == 0) begin
      $display("raycast_wall_slice_core test passed");
    end else begin
      $display("raycast_wall_slice_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
